// ===== design/pal_pkg.sv =====
// ============================================================================
// Positional array list package
// Command and status codes, field widths and the result record shared by the
// positional array list modules.
// ============================================================================
package pal_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int POS2_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 8;
  localparam int COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_SWAP       = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [FPOS_W-1:0]   found_position;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

// ===== design/pal_mem.sv =====
// ============================================================================
// Positional array list entry memory
// Synchronous memory with one write port and one registered read port.
// ============================================================================
module pal_mem #(
  parameter int DEPTH = 256
) (
  input  logic                                          clk_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [pal_pkg::VALUE_W-1:0]                   rdata_o,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [pal_pkg::VALUE_W-1:0]                   wdata_i
);
  import pal_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pal_seq.sv =====
// ============================================================================
// Positional array list sequencer
// Decodes each command, walks the entry memory one entry per cycle for
// shifts and searches, and keeps the entry count.
// ============================================================================
module pal_seq #(
  parameter int CAPACITY = 256
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_stall_o,
  input  logic [pal_pkg::CMD_W-1:0]                        command_i,
  input  logic signed [pal_pkg::VALUE_W-1:0]               value_i,
  input  logic signed [pal_pkg::POS_W-1:0]                 position_i,
  input  logic [pal_pkg::POS2_W-1:0]                       second_position_i,
  output logic                                             mem_re_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_raddr_o,
  input  logic [pal_pkg::VALUE_W-1:0]                      mem_rdata_i,
  output logic                                             mem_we_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_waddr_o,
  output logic [pal_pkg::VALUE_W-1:0]                      mem_wdata_o,
  output logic                                             load_o,
  output pal_pkg::result_t                                 res_o,
  input  logic                                             out_free_i
);
  import pal_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SHIFT  = 7'b0000010,
    S_SWAP_A = 7'b0000100,
    S_SWAP_B = 7'b0001000,
    S_SWAP_C = 7'b0010000,
    S_FIND   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic                up_q, up_d;
  logic                pv_q, pv_d;
  logic [IW-1:0]       wa_q, wa_d;
  logic [IW-1:0]       a_q, a_d;
  logic [IW-1:0]       b_q, b_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [VALUE_W-1:0]  tmp_q, tmp_d;
  status_e             status_q, status_d;
  logic                found_q, found_d;
  logic [FPOS_W-1:0]   fpos_q, fpos_d;

  cmd_e                cmd;
  logic [CW+9:0]       cnt_c, pos_c, pos2_c;
  logic                pos_neg, is_full, is_empty, swap_bad;
  logic [CW-1:0]       last, ins_at, rem_at, cur_m1, cur_p1;
  logic [CW+7:0]       cur_ext;
  logic [CW+8:0]       cnt_ext;

  assign cmd      = cmd_e'(command_i);
  assign cnt_c    = {10'b0, count_q};
  assign pos_c    = {{(CW + 1){1'b0}}, position_i[POS_W-2:0]};
  assign pos2_c   = {{(CW + 2){1'b0}}, second_position_i};
  assign pos_neg  = position_i[POS_W-1];
  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign last     = count_q - 1'b1;
  assign swap_bad = pos_neg || (pos_c >= cnt_c) || (pos2_c >= cnt_c);
  assign cur_m1   = cur_q - 1'b1;
  assign cur_p1   = cur_q + 1'b1;
  assign cur_ext  = {8'b0, cur_q};
  assign cnt_ext  = {9'b0, count_q};

  // Insert target: negative goes to the front, beyond the count appends.
  always_comb begin
    case (cmd)
      CMD_PUSH_FRONT: ins_at = '0;
      CMD_INSERT_AT: begin
        if (pos_neg) begin
          ins_at = '0;
        end else if (pos_c > cnt_c) begin
          ins_at = count_q;
        end else begin
          ins_at = pos_c[CW-1:0];
        end
      end
      default: ins_at = count_q;
    endcase
  end

  // Remove target: negative takes the front, at or beyond the count the back.
  always_comb begin
    case (cmd)
      CMD_POP_FRONT: rem_at = '0;
      CMD_REMOVE_AT: begin
        if (pos_neg) begin
          rem_at = '0;
        end else if (pos_c >= cnt_c) begin
          rem_at = last;
        end else begin
          rem_at = pos_c[CW-1:0];
        end
      end
      default: rem_at = last;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    lim_d       = lim_q;
    up_d        = up_q;
    pv_d        = 1'b0;
    wa_d        = wa_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    status_d    = status_q;
    found_d     = found_q;
    fpos_d      = fpos_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = val_q;
    load_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          status_d = ST_OK;
          found_d  = 1'b0;
          fpos_d   = '0;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (is_full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                up_d    = 1'b1;
                cur_d   = count_q;
                lim_d   = ins_at;
                state_d = S_SHIFT;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                up_d    = 1'b0;
                cur_d   = rem_at;
                lim_d   = last;
                state_d = S_SHIFT;
              end
            end
            CMD_SWAP: begin
              if (swap_bad) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_c[IW-1:0];
                a_d         = pos_c[IW-1:0];
                b_d         = pos2_c[IW-1:0];
                state_d     = S_SWAP_A;
              end
            end
            CMD_FIND: begin
              if (is_empty) begin
                state_d = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                cur_d       = '0;
                lim_d       = last;
                state_d     = S_FIND;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SHIFT: begin
        // The write of the entry read last cycle trails the read by one place.
        if (pv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wa_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (cur_q != lim_q) begin
          mem_re_o = 1'b1;
          pv_d     = 1'b1;
          wa_d     = cur_q[IW-1:0];
          if (up_q) begin
            mem_raddr_o = cur_m1[IW-1:0];
            cur_d       = cur_m1;
          end else begin
            mem_raddr_o = cur_p1[IW-1:0];
            cur_d       = cur_p1;
          end
        end else if (!pv_q) begin
          if (up_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = lim_q[IW-1:0];
            mem_wdata_o = val_q;
            count_d     = count_q + 1'b1;
          end else begin
            count_d     = count_q - 1'b1;
          end
          state_d = S_DONE;
        end
      end

      S_SWAP_A: begin
        tmp_d       = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = b_q;
        state_d     = S_SWAP_B;
      end

      S_SWAP_B: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = a_q;
        mem_wdata_o = mem_rdata_i;
        state_d     = S_SWAP_C;
      end

      S_SWAP_C: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = b_q;
        mem_wdata_o = tmp_q;
        state_d     = S_DONE;
      end

      S_FIND: begin
        if (mem_rdata_i == val_q) begin
          found_d = 1'b1;
          fpos_d  = cur_ext[FPOS_W-1:0];
          state_d = S_DONE;
        end else if (cur_q == lim_q) begin
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cur_p1[IW-1:0];
          cur_d       = cur_p1;
        end
      end

      S_DONE: begin
        if (out_free_i) begin
          load_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    lim_q    <= lim_d;
    up_q     <= up_d;
    wa_q     <= wa_d;
    a_q      <= a_d;
    b_q      <= b_d;
    val_q    <= val_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  assign res_o = '{status:         status_q,
                   found:          found_q,
                   found_position: fpos_q,
                   entry_count:    cnt_ext[COUNT_W-1:0]};

endmodule

// ===== design/pal_out.sv =====
// ============================================================================
// Positional array list result register
// Holds one finished result item until the receiver takes it.
// ============================================================================
module pal_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  pal_pkg::result_t                   res_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pal_pkg::STATUS_W-1:0]       status_o,
  output logic                               found_o,
  output logic [pal_pkg::FPOS_W-1:0]         found_position_o,
  output logic [pal_pkg::COUNT_W-1:0]        entry_count_o
);
  import pal_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign free_o           = !valid_q || !out_stall_i;
  assign out_valid_o      = valid_q;
  assign status_o         = res_q.status;
  assign found_o          = res_q.found;
  assign found_position_o = res_q.found_position;
  assign entry_count_o    = res_q.entry_count;

endmodule

// ===== design/positional_array_list.sv =====
// ============================================================================
// Positional array list
// Ordered list of signed 32-bit entries held in one synchronous memory, with
// inserts, removals, swaps and searches by position or value.
// ============================================================================
//
//   Channel  Direction  Handshake               Fields
//   -------  ---------  ----------------------  ---------------------------------
//   in       to block   in_valid_i/in_stall_o   command, value, position,
//                                               second_position
//   out      from block out_valid_o/out_stall_i status, found, found_position,
//                                               entry_count
//
// One item is worked on at a time; the next is accepted only after the
// result of the last one has been loaded. Every moved entry costs one
// read-modify-write step on the memory's single read and single write port.
// An insert at k moves count - k entries and a removal at k moves
// count - k - 1. A find reads the entries from the front until one matches
// or the last has been read, and a swap reads both entries and then writes
// each to the other's place. A full, empty or out-of-range command, or a
// find on an empty list, moves no entry and goes straight to its result.
// Reset clears the entry count and the control state only; the memory is not
// cleared, as only entries below the count are ever read.
// The result register lets a new item be accepted while the previous result
// waits; a stall on the output only holds the sequencer once it has a second
// result ready.
//
module positional_array_list #(
  parameter int CAPACITY = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pal_pkg::CMD_W-1:0]             command_i,
  input  logic signed [pal_pkg::VALUE_W-1:0]    value_i,
  input  logic signed [pal_pkg::POS_W-1:0]      position_i,
  input  logic [pal_pkg::POS2_W-1:0]            second_position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pal_pkg::STATUS_W-1:0]          status_o,
  output logic                                  found_o,
  output logic [pal_pkg::FPOS_W-1:0]            found_position_o,
  output logic [pal_pkg::COUNT_W-1:0]           entry_count_o
);
  import pal_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               load;
  logic               out_free;
  result_t            res;

  // The entry memory holds the list in order, entry zero at the front.
  pal_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // The sequencer decodes each item and steps through the memory, reading
  // one entry and writing the one read in the previous cycle.
  pal_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .value_i           (value_i),
    .position_i        (position_i),
    .second_position_i (second_position_i),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .load_o            (load),
    .res_o             (res),
    .out_free_i        (out_free)
  );

  // The result register parts the output handshake from the sequencer.
  pal_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .res_i            (res),
    .free_o           (out_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  // The memory is never written while the block is waiting for an item.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !mem_we)
    else $error("entry memory written while idle");

  // A match is only ever reported with a good status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("find reported with a bad status");

  // A full list reports exactly its capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == 9'(CAPACITY))
    else $error("full status with wrong entry count");

  // An empty list reports no entries.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with non-zero entry count");

  // A newly loaded result follows the hand-over of the previous one.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over one not yet taken");

endmodule
